// ----- design/covalent_bond_finder_macros.svh -----
// Assertion macros used by the checker file of the bond finder.
`ifndef COVALENT_BOND_FINDER_MACROS_SVH
`define COVALENT_BOND_FINDER_MACROS_SVH

// Clocked property that is switched off while the active-low reset is asserted.
`define CBF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);

// Clocked property that is checked in every cycle, reset cycles included.
`define CBF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/cbf_pkg.sv -----
// Types, widths, register codes and the covalent radius table of the bond finder.
`timescale 1ns / 1ps

package cbf_pkg;

    // Field widths of the item channels.
    localparam int COORD_W   = 20;
    localparam int ELEM_W    = 7;
    localparam int OUT_IDX_W = 24;
    localparam int MARGIN_W  = 8;

    // Datapath widths: radius, bond limit, coordinate difference and its square.
    localparam int RADIUS_W = 10;
    localparam int LIM_W    = RADIUS_W + 2;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 2 * DIFF_W;

    // Configuration register indexes and reset values.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER_MARGIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER_MARGIN = 1'b1;
    localparam logic [MARGIN_W-1:0]  LOWER_MARGIN_RST = 8'd128;
    localparam logic [MARGIN_W-1:0]  UPPER_MARGIN_RST = 8'd77;

    // One stored atom: position and element number.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [ELEM_W-1:0]         elem;
    } t_atom;

    // Covalent radius per element in 1/256 angstrom; unknown elements read as zero.
    localparam logic [RADIUS_W-1:0] RADIUS_ROM [0:127] = '{
        0, 79, 72, 328, 246, 215, 195, 182, 169, 146, 148, 425, 361, 310, 284, 274,
        269, 261, 271, 520, 451, 435, 410, 392,
        356, 356, 338, 323, 317, 338, 312, 312, 307, 305, 307, 307, 297, 563, 499,
        486, 448, 420, 394, 376, 374, 364, 356, 371,
        369, 364, 356, 356, 353, 356, 358, 625, 550, 530, 522, 520, 515, 509, 507,
        507, 502, 497, 492, 492, 484, 486, 479, 479,
        448, 435, 415, 387, 369, 361, 348, 348, 338, 371, 374, 379, 358, 384, 384,
        666, 566, 550, 527, 512, 502, 486, 479, 461,
        433, 410, 410, 410, 410, 410, 410, 410, 410, 410, 410, 410, 410, 410, 410,
        410, 410, 410, 410, 410, 410, 410, 410,
        0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    function automatic logic [RADIUS_W-1:0] radius_of(input logic [ELEM_W-1:0] e);
        return RADIUS_ROM[e];
    endfunction

endpackage

// ----- design/cbf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/cbf_square.sv -----
// Shared squaring unit with a registered product.
`timescale 1ns / 1ps

module cbf_square
    import cbf_pkg::*;
(
    input  logic              i_clk,
    input  logic [DIFF_W-1:0] i_opnd,
    output logic [SQ_W-1:0]   o_sq
);

    logic [SQ_W-1:0] prod;

    // Unsigned square of a magnitude; the full product fits the result.
    assign prod = i_opnd * i_opnd;

    always_ff @(posedge i_clk) begin
        o_sq <= prod;
    end

endmodule

// ----- design/covalent_bond_finder.sv -----
// Top level of the covalent bond finder: atom store, scan sequencer and bond output.
//
//  Channel   Handshake            Payload
//  -------   ------------------   ------------------------------------------------
//  atom in   i_valid / o_stall    i_pos_x/y/z, i_element_number, i_residue_start,
//                                 i_set_start
//  bond out  o_valid / i_stall    o_first_atom, o_second_atom, o_bond_kind,
//                                 o_last_of_run
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// An atom is compared with each stored atom of the previous and current residue in
// turn; each comparison runs on the shared squaring unit through store read, difference,
// five squares, last compare and decision. An atom with stored neighbors therefore holds
// the input stalled until its scan ends, through a flush step when it finds a bond, and
// while a waiting bond is held back by the output stall.
// Reset is synchronous and clears the counters, margins and handshake state; the atom
// store is not cleared, since only entries that were written are ever read.
// A stalled output holds its bond while the scan waits for room for the next one.
`timescale 1ns / 1ps

module covalent_bond_finder
    import cbf_pkg::*;
#(
    parameter int MAX_RESIDUE_ATOMS = 32,
    parameter int INDEX_BITS        = 24
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [COORD_W-1:0]  i_pos_x,
    input  logic signed [COORD_W-1:0]  i_pos_y,
    input  logic signed [COORD_W-1:0]  i_pos_z,
    input  logic [ELEM_W-1:0]          i_element_number,
    input  logic                       i_residue_start,
    input  logic                       i_set_start,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [OUT_IDX_W-1:0]       o_first_atom,
    output logic [OUT_IDX_W-1:0]       o_second_atom,
    output logic                       o_bond_kind,
    output logic                       o_last_of_run,
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [MARGIN_W-1:0]        i_cfg_data
);

    localparam int KW    = $clog2(MAX_RESIDUE_ATOMS);
    localparam int CW    = $clog2(MAX_RESIDUE_ATOMS + 1);
    localparam int AW    = KW + 1;
    localparam int DEPTH = 2 ** AW;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_READ  = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_SQ_X  = 4'd3;
    localparam logic [3:0] ST_SQ_Y  = 4'd4;
    localparam logic [3:0] ST_SQ_Z  = 4'd5;
    localparam logic [3:0] ST_SQ_LO = 4'd6;
    localparam logic [3:0] ST_SQ_HI = 4'd7;
    localparam logic [3:0] ST_CMP   = 4'd8;
    localparam logic [3:0] ST_EMIT  = 4'd9;
    localparam logic [3:0] ST_FLUSH = 4'd10;

    logic [3:0]                r_state;
    logic [3:0]                n_state;
    logic                      r_bank;
    logic [CW-1:0]             r_cur_cnt;
    logic [CW-1:0]             r_prev_cnt;
    logic [INDEX_BITS-1:0]     r_counter;
    logic [MARGIN_W-1:0]       r_lower;
    logic [MARGIN_W-1:0]       r_upper;

    logic [CW-1:0]             r_scan_prev;
    logic [CW-1:0]             r_scan_cur;
    logic [KW-1:0]             r_k;
    logic                      r_kind;
    logic [INDEX_BITS-1:0]     r_idx;
    logic [INDEX_BITS-1:0]     r_second;
    logic signed [COORD_W-1:0] r_new_x;
    logic signed [COORD_W-1:0] r_new_y;
    logic signed [COORD_W-1:0] r_new_z;
    logic [RADIUS_W-1:0]       r_new_rad;

    logic [DIFF_W-1:0]         r_dx;
    logic [DIFF_W-1:0]         r_dy;
    logic [DIFF_W-1:0]         r_dz;
    logic [LIM_W-1:0]          r_dlo;
    logic [LIM_W-1:0]          r_dhi;
    logic [SQ_W-1:0]           r_d2;
    logic                      r_lo_ok;
    logic                      r_hi_ok;

    logic                      r_pend_v;
    logic [INDEX_BITS-1:0]     r_pend_idx;
    logic                      r_pend_kind;

    logic                      r_o_valid;
    logic [OUT_IDX_W-1:0]      r_o_first;
    logic [OUT_IDX_W-1:0]      r_o_second;
    logic                      r_o_kind;
    logic                      r_o_last;

    logic                      accept;
    logic [CW-1:0]             cur0;
    logic [CW-1:0]             prev0;
    logic [INDEX_BITS-1:0]     cnt0;
    logic                      swap;
    logic                      bank_a;
    logic [CW-1:0]             cur_a;
    logic [CW-1:0]             prev_a;
    logic [INDEX_BITS-1:0]     base_prev_a;

    t_atom                     wr_atom;
    t_atom                     rd_atom;
    logic [AW-1:0]             waddr;
    logic [AW-1:0]             raddr;

    logic signed [DIFF_W-1:0]  dx_s;
    logic signed [DIFF_W-1:0]  dy_s;
    logic signed [DIFF_W-1:0]  dz_s;
    logic [RADIUS_W:0]         d_sum;
    logic signed [LIM_W-1:0]   lo_s;
    logic [LIM_W-1:0]          hi_u;

    logic [DIFF_W-1:0]         sq_opnd;
    logic [SQ_W-1:0]           sq;

    logic [CW-1:0]             k_next_cnt;
    logic                      last_prev;
    logic                      scan_end;
    logic                      bonded;
    logic                      out_free;
    logic                      hold;
    logic                      push;
    logic                      push_last;

    function automatic logic [DIFF_W-1:0] mag(input logic signed [DIFF_W-1:0] v);
        return v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    // Residue bookkeeping for an arriving atom: set start, then residue switch.
    assign accept      = i_valid && (r_state == ST_IDLE);
    assign cur0        = i_set_start ? '0 : r_cur_cnt;
    assign prev0       = i_set_start ? '0 : r_prev_cnt;
    assign cnt0        = i_set_start ? '0 : r_counter;
    assign swap        = i_residue_start || (cur0 == CW'(MAX_RESIDUE_ATOMS));
    assign bank_a      = swap ? ~r_bank : r_bank;
    assign cur_a       = swap ? '0 : cur0;
    assign prev_a      = swap ? cur0 : prev0;
    assign base_prev_a = cnt0 - INDEX_BITS'(cur_a) - INDEX_BITS'(prev_a);

    // The new atom is written to its slot at once; the scan only reads lower slots.
    assign wr_atom = '{x: i_pos_x, y: i_pos_y, z: i_pos_z, elem: i_element_number};
    assign waddr   = {bank_a, cur_a[KW-1:0]};
    assign raddr   = {r_kind ? ~r_bank : r_bank, r_k};

    cbf_ram #(
        .WIDTH ($bits(t_atom)),
        .DEPTH (DEPTH)
    ) u_atom_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (waddr),
        .i_wdata (wr_atom),
        .i_raddr (raddr),
        .o_rdata (rd_atom)
    );

    // Differences to the stored atom and the two bond limits.
    always_comb begin
        dx_s  = DIFF_W'(r_new_x) - DIFF_W'(rd_atom.x);
        dy_s  = DIFF_W'(r_new_y) - DIFF_W'(rd_atom.y);
        dz_s  = DIFF_W'(r_new_z) - DIFF_W'(rd_atom.z);
        d_sum = {1'b0, radius_of(rd_atom.elem)} + {1'b0, r_new_rad};
        lo_s  = $signed({1'b0, d_sum}) - $signed({{(LIM_W - MARGIN_W){1'b0}}, r_lower});
        hi_u  = {1'b0, d_sum} + {{(LIM_W - MARGIN_W){1'b0}}, r_upper};
    end

    // Operand selection for the shared squaring unit.
    always_comb begin
        case (r_state)
            ST_SQ_X:  sq_opnd = r_dx;
            ST_SQ_Y:  sq_opnd = r_dy;
            ST_SQ_Z:  sq_opnd = r_dz;
            ST_SQ_LO: sq_opnd = DIFF_W'(r_dlo);
            ST_SQ_HI: sq_opnd = DIFF_W'(r_dhi);
            default:  sq_opnd = '0;
        endcase
    end

    cbf_square u_square (
        .i_clk  (i_clk),
        .i_opnd (sq_opnd),
        .o_sq   (sq)
    );

    // Scan position and output room.
    assign k_next_cnt = CW'(r_k) + CW'(1);
    assign last_prev  = r_kind && (k_next_cnt == r_scan_prev);
    assign scan_end   = r_kind ? (last_prev && (r_scan_cur == '0))
                               : (k_next_cnt == r_scan_cur);
    assign bonded     = r_lo_ok && r_hi_ok;
    assign out_free   = !r_o_valid || !i_stall;
    assign hold       = bonded && r_pend_v && !out_free;
    assign push       = ((r_state == ST_EMIT) && bonded && r_pend_v && out_free) ||
                        ((r_state == ST_FLUSH) && out_free);
    assign push_last  = (r_state == ST_FLUSH);

    // Sequencer next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && ((prev_a != '0) || (cur_a != '0))) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_SQ_X;
            ST_SQ_X:  n_state = ST_SQ_Y;
            ST_SQ_Y:  n_state = ST_SQ_Z;
            ST_SQ_Z:  n_state = ST_SQ_LO;
            ST_SQ_LO: n_state = ST_SQ_HI;
            ST_SQ_HI: n_state = ST_CMP;
            ST_CMP:   n_state = ST_EMIT;
            ST_EMIT: begin
                if (hold) begin
                    n_state = ST_EMIT;
                end else if (scan_end) begin
                    n_state = (bonded || r_pend_v) ? ST_FLUSH : ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state: sequencer, residue counts, atom counter, margins, pending bond.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_bank     <= 1'b0;
            r_cur_cnt  <= '0;
            r_prev_cnt <= '0;
            r_counter  <= '0;
            r_lower    <= LOWER_MARGIN_RST;
            r_upper    <= UPPER_MARGIN_RST;
            r_pend_v   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_bank     <= bank_a;
                r_cur_cnt  <= cur_a + CW'(1);
                r_prev_cnt <= prev_a;
                r_counter  <= cnt0 + INDEX_BITS'(1);
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOWER_MARGIN: r_lower <= i_cfg_data;
                    CFG_UPPER_MARGIN: r_upper <= i_cfg_data;
                    default: ;
                endcase
            end
            if ((r_state == ST_EMIT) && !hold && bonded) begin
                r_pend_v <= 1'b1;
            end else if ((r_state == ST_FLUSH) && out_free) begin
                r_pend_v <= 1'b0;
            end
            if (push) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Scan and datapath registers.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_scan_prev <= prev_a;
            r_scan_cur  <= cur_a;
            r_k         <= '0;
            r_kind      <= (prev_a != '0);
            r_idx       <= base_prev_a;
            r_second    <= cnt0;
            r_new_x     <= i_pos_x;
            r_new_y     <= i_pos_y;
            r_new_z     <= i_pos_z;
            r_new_rad   <= radius_of(i_element_number);
        end
        if (r_state == ST_LOAD) begin
            r_dx  <= mag(dx_s);
            r_dy  <= mag(dy_s);
            r_dz  <= mag(dz_s);
            r_dlo <= lo_s[LIM_W-1] ? LIM_W'(-lo_s) : LIM_W'(lo_s);
            r_dhi <= hi_u;
        end
        // The squarer output is registered and belongs to the operand of the previous state.
        case (r_state)
            ST_SQ_Y:  r_d2    <= sq;
            ST_SQ_Z:  r_d2    <= r_d2 + sq;
            ST_SQ_LO: r_d2    <= r_d2 + sq;
            ST_SQ_HI: r_lo_ok <= (sq < r_d2);
            ST_CMP:   r_hi_ok <= (r_d2 < sq);
            default: ;
        endcase
        if ((r_state == ST_EMIT) && !hold) begin
            r_idx <= r_idx + INDEX_BITS'(1);
            if (last_prev) begin
                r_kind <= 1'b0;
                r_k    <= '0;
            end else begin
                r_k <= r_k + KW'(1);
            end
            if (bonded) begin
                r_pend_idx  <= r_idx;
                r_pend_kind <= r_kind;
            end
        end
        if (push) begin
            r_o_first  <= OUT_IDX_W'(r_pend_idx);
            r_o_second <= OUT_IDX_W'(r_second);
            r_o_kind   <= r_pend_kind;
            r_o_last   <= push_last;
        end
    end

    assign o_stall       = (r_state != ST_IDLE);
    assign o_valid       = r_o_valid;
    assign o_first_atom  = r_o_first;
    assign o_second_atom = r_o_second;
    assign o_bond_kind   = r_o_kind;
    assign o_last_of_run = r_o_last;

endmodule

// ----- design/cbf_checker.sv -----
// Port-level checker for the bond finder and its bind to the top level.
`timescale 1ns / 1ps
`include "covalent_bond_finder_macros.svh"

module cbf_checker
    import cbf_pkg::*;
(
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [OUT_IDX_W-1:0]      o_first_atom,
    input logic [OUT_IDX_W-1:0]      o_second_atom,
    input logic                      o_bond_kind,
    input logic                      o_last_of_run
);

    logic [2*OUT_IDX_W+1:0] bond_word;

    // All fields of the bond item in one word.
    assign bond_word = {o_first_atom, o_second_atom, o_bond_kind, o_last_of_run};

    // After reset no bond is shown and the block takes atoms.
    `CBF_ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_valid && !o_stall,
        "bond finder not idle after reset")

    // A stalled bond item holds its contents.
    `CBF_ASSERT(a_out_hold, i_clk, i_rst_n,
        o_valid && i_stall |=> o_valid && $stable(bond_word),
        "stalled bond item changed")

    // While a run is not finished the final bond is still pending, so the input stays stalled.
    `CBF_ASSERT(a_run_busy, i_clk, i_rst_n, o_valid && !o_last_of_run |-> o_stall,
        "input open before the run ended")

    // Within a run the new atom stays the same and previous-residue bonds come first.
    `CBF_ASSERT(a_run_order, i_clk, i_rst_n,
        o_valid && !i_stall && !o_last_of_run |=> !o_valid ||
            (o_second_atom == $past(o_second_atom) && ($past(o_bond_kind) || !o_bond_kind)),
        "bond run out of order")

endmodule

bind covalent_bond_finder cbf_checker u_cbf_checker (.*);
